// ----- rtl/rcbp_pkg.sv -----
package rcbp_pkg;

    // Fixed widths of the byte, the frame index, the accumulator, the gain select and the direction flags
    localparam int BYTE_W  = 8;
    localparam int COUNT_W = 7;
    localparam int ACC_W   = 32;
    localparam int SEL_W   = 2;
    localparam int DIR_W   = 4;

    // Default frame limit, bytes
    localparam int MAX_FRAME_BYTES_DEFAULT = 64;

    // Queue between classifier and executor; power of two
    localparam int QUEUE_DEPTH = 2;

    // Byte codes
    localparam logic [BYTE_W-1:0] CODE_NEWLINE    = 8'h0A;
    localparam logic [BYTE_W-1:0] CODE_GEAR_LOW   = 8'h59;
    localparam logic [BYTE_W-1:0] CODE_GEAR_HIGH  = 8'h58;
    localparam logic [BYTE_W-1:0] CODE_LETTER_LO  = 8'h41;
    localparam logic [BYTE_W-1:0] CODE_LETTER_HI  = 8'h48;
    localparam logic [BYTE_W-1:0] CODE_LETTER_OFS = 8'h40;
    localparam logic [BYTE_W-1:0] CODE_OPEN       = 8'h7B;
    localparam logic [BYTE_W-1:0] CODE_CLOSE      = 8'h7D;
    localparam logic [BYTE_W-1:0] CODE_PID        = 8'h50;
    localparam logic [BYTE_W-1:0] CODE_FLASH      = 8'h57;
    localparam logic [BYTE_W-1:0] CODE_GAIN_LO    = 8'h30;
    localparam logic [BYTE_W-1:0] CODE_GAIN_HI    = 8'h33;
    localparam logic [BYTE_W-1:0] CODE_DIGIT_ZERO = 8'h30;

    // Direction codes after the letter offset is removed
    localparam logic [3:0] DCODE_FWD       = 4'd1;
    localparam logic [3:0] DCODE_RIGHT_LO  = 4'd2;
    localparam logic [3:0] DCODE_RIGHT_HI  = 4'd4;
    localparam logic [3:0] DCODE_BACK      = 4'd5;
    localparam logic [3:0] DCODE_LEFT_LO   = 4'd6;
    localparam logic [3:0] DCODE_LEFT_HI   = 4'd8;

    // Direction flag vectors: bit0 fwd, bit1 back, bit2 left, bit3 right
    localparam logic [DIR_W-1:0] DIR_STOP  = 4'b0000;
    localparam logic [DIR_W-1:0] DIR_FWD   = 4'b0001;
    localparam logic [DIR_W-1:0] DIR_BACK  = 4'b0010;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 4'b0100;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 4'b1000;

    // Classified byte, as queued between the two halves
    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              dir_write;
        logic [DIR_W-1:0]  dir_value;
        logic              gear_write;
        logic              gear_value;
        logic              is_open;
        logic              is_close;
    } item_t;

    // Queue to executor
    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_out_t;

    // One result beat
    typedef struct packed {
        logic                    drive_forward;
        logic                    drive_backward;
        logic                    turn_left;
        logic                    turn_right;
        logic                    speed_high;
        logic                    frame_done;
        logic                    pid_request;
        logic                    flash_request;
        logic                    gain_update;
        logic [SEL_W-1:0]        gain_select;
        logic signed [ACC_W-1:0] gain_hundredths;
        logic [COUNT_W-1:0]      frame_length;
    } result_t;

endpackage

// ----- rtl/remote_command_byte_parser_top.sv -----
// Remote command byte parser.
//
// Input channel (s_valid / s_ready / s_rx_byte): one received serial byte per
// beat. Every byte is decoded as a drive command and, while a '{' ... '}'
// frame is open, collected into the frame (index, bytes 1 and 3, saturating
// decimal accumulator).
// Result channel (m_valid / m_ready / m_*): exactly one result beat per input
// beat, in order: drive flags and gear after the byte, plus on '}' the frame
// end with its length and a PID, flash or gain update request.
// An accepted byte is written into the queue, then popped by the executor
// and registered in the output register, which offers its result beat.
// Throughput: one byte per cycle while the receiver takes every beat; the
// classifier, two-entry queue and executor with output register all advance.
// Receiver stall: the output register holds its beat, the queue absorbs up to
// two more bytes, then s_ready drops until the receiver takes a beat.
// Reset (aresetn low, synchronous): frame state clears, drive flags stop,
// low gear is selected, the queue empties and m_valid drops.
module remote_command_byte_parser_top #(
    parameter int MAX_FRAME_BYTES = rcbp_pkg::MAX_FRAME_BYTES_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [rcbp_pkg::BYTE_W-1:0]          s_rx_byte,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_drive_forward,
    output logic                                 m_drive_backward,
    output logic                                 m_turn_left,
    output logic                                 m_turn_right,
    output logic                                 m_speed_high,
    output logic                                 m_frame_done,
    output logic                                 m_pid_request,
    output logic                                 m_flash_request,
    output logic                                 m_gain_update,
    output logic [rcbp_pkg::SEL_W-1:0]           m_gain_select,
    output logic signed [rcbp_pkg::ACC_W-1:0]    m_gain_hundredths,
    output logic [rcbp_pkg::COUNT_W-1:0]         m_frame_length
);

    logic                 push;
    logic                 queue_full;
    logic                 pop;
    rcbp_pkg::item_t      push_item;
    rcbp_pkg::queue_out_t head;
    rcbp_pkg::result_t    result;

    // Classify each byte as it is accepted
    rcbp_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_rx_byte  (s_rx_byte),
        .queue_full (queue_full),
        .push       (push),
        .item       (push_item)
    );

    // Decouple acceptance from execution
    rcbp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .head      (head)
    );

    // Update drive and frame state, register the result beat
    rcbp_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .result  (result)
    );

    assign m_drive_forward   = result.drive_forward;
    assign m_drive_backward  = result.drive_backward;
    assign m_turn_left       = result.turn_left;
    assign m_turn_right      = result.turn_right;
    assign m_speed_high      = result.speed_high;
    assign m_frame_done      = result.frame_done;
    assign m_pid_request     = result.pid_request;
    assign m_flash_request   = result.flash_request;
    assign m_gain_update     = result.gain_update;
    assign m_gain_select     = result.gain_select;
    assign m_gain_hundredths = result.gain_hundredths;
    assign m_frame_length    = result.frame_length;

endmodule

// ----- rtl/rcbp_front.sv -----
module rcbp_front (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rcbp_pkg::BYTE_W-1:0]       s_rx_byte,
    input  logic                              queue_full,
    output logic                              push,
    output rcbp_pkg::item_t                   item
);

    logic [3:0]                  dcode;
    logic [rcbp_pkg::DIR_W-1:0]  dir_decoded;
    logic                        is_letter;

    assign s_ready = !queue_full;
    assign push    = s_valid && !queue_full;

    // Drive code: letters are mapped down onto the numeric codes
    assign is_letter = (s_rx_byte >= rcbp_pkg::CODE_LETTER_LO) &&
                       (s_rx_byte <= rcbp_pkg::CODE_LETTER_HI);

    always_comb begin
        dcode = is_letter ? 4'(s_rx_byte - rcbp_pkg::CODE_LETTER_OFS) : s_rx_byte[3:0];
        if (dcode == rcbp_pkg::DCODE_FWD) begin
            dir_decoded = rcbp_pkg::DIR_FWD;
        end else if (dcode == rcbp_pkg::DCODE_BACK) begin
            dir_decoded = rcbp_pkg::DIR_BACK;
        end else if (dcode >= rcbp_pkg::DCODE_RIGHT_LO && dcode <= rcbp_pkg::DCODE_RIGHT_HI) begin
            dir_decoded = rcbp_pkg::DIR_RIGHT;
        end else if (dcode >= rcbp_pkg::DCODE_LEFT_LO && dcode <= rcbp_pkg::DCODE_LEFT_HI) begin
            dir_decoded = rcbp_pkg::DIR_LEFT;
        end else begin
            dir_decoded = rcbp_pkg::DIR_STOP;
        end
    end

    always_comb begin
        item.rx_byte    = s_rx_byte;
        item.dir_write  = 1'b0;
        item.dir_value  = rcbp_pkg::DIR_STOP;
        item.gear_write = 1'b0;
        item.gear_value = 1'b0;
        priority if (s_rx_byte > rcbp_pkg::CODE_NEWLINE) begin
            item.dir_write = 1'b1;
            item.dir_value = is_letter ? dir_decoded : rcbp_pkg::DIR_STOP;
            if (s_rx_byte == rcbp_pkg::CODE_GEAR_LOW) begin
                item.gear_write = 1'b1;
                item.gear_value = 1'b0;
            end else if (s_rx_byte == rcbp_pkg::CODE_GEAR_HIGH) begin
                item.gear_write = 1'b1;
                item.gear_value = 1'b1;
            end
        end else if (s_rx_byte < rcbp_pkg::CODE_NEWLINE) begin
            // numeric codes always select high gear
            item.dir_write  = 1'b1;
            item.dir_value  = dir_decoded;
            item.gear_write = 1'b1;
            item.gear_value = 1'b1;
        end else begin
            // newline: hold drive state
        end
        item.is_open  = (s_rx_byte == rcbp_pkg::CODE_OPEN);
        item.is_close = (s_rx_byte == rcbp_pkg::CODE_CLOSE);
    end

endmodule

// ----- rtl/rcbp_queue.sv -----
module rcbp_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  rcbp_pkg::item_t      push_item,
    output logic                 full,
    input  logic                 pop,
    output rcbp_pkg::queue_out_t head
);

    localparam int PTR_W = (rcbp_pkg::QUEUE_DEPTH > 1) ? $clog2(rcbp_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(rcbp_pkg::QUEUE_DEPTH + 1);

    rcbp_pkg::item_t    entry_reg [rcbp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == CNT_W'(rcbp_pkg::QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/rcbp_back.sv -----
module rcbp_back #(
    parameter int MAX_FRAME_BYTES = rcbp_pkg::MAX_FRAME_BYTES_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rcbp_pkg::queue_out_t head,
    output logic                 pop,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rcbp_pkg::result_t    result
);

    localparam int SUM_W = rcbp_pkg::ACC_W + 5;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);

    // Frame and drive state
    logic                                 collecting_reg, collecting_next;
    logic [rcbp_pkg::COUNT_W-1:0]         count_reg, count_next;
    logic [rcbp_pkg::BYTE_W-1:0]          byte_one_reg, byte_one_next;
    logic [rcbp_pkg::BYTE_W-1:0]          byte_three_reg, byte_three_next;
    logic signed [rcbp_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic [rcbp_pkg::DIR_W-1:0]           dir_reg, dir_next;
    logic                                 gear_reg, gear_next;

    logic                                 out_valid_reg;
    rcbp_pkg::result_t                    result_reg, result_next;

    logic                                 collect_now;
    logic signed [SUM_W-1:0]              acc_wide, times_ten, digit_term, acc_sum;
    logic signed [rcbp_pkg::ACC_W-1:0]    acc_sat;

    assign pop     = head.valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign result  = result_reg;

    // Horner step with saturation
    always_comb begin
        acc_wide   = SUM_W'(acc_reg);
        times_ten  = (acc_wide <<< 3) + (acc_wide <<< 1);
        digit_term = SUM_W'($signed({1'b0, head.item.rx_byte}))
                   - SUM_W'($signed({1'b0, rcbp_pkg::CODE_DIGIT_ZERO}));
        acc_sum    = times_ten + digit_term;
        priority if (acc_sum > SAT_MAX) begin
            acc_sat = rcbp_pkg::ACC_W'(SAT_MAX);
        end else if (acc_sum < SAT_MIN) begin
            acc_sat = rcbp_pkg::ACC_W'(SAT_MIN);
        end else begin
            acc_sat = acc_sum[rcbp_pkg::ACC_W-1:0];
        end
    end

    always_comb begin
        dir_next        = head.item.dir_write  ? head.item.dir_value  : dir_reg;
        gear_next       = head.item.gear_write ? head.item.gear_value : gear_reg;
        collect_now     = collecting_reg || head.item.is_open;
        collecting_next = collect_now;
        count_next      = count_reg;
        byte_one_next   = byte_one_reg;
        byte_three_next = byte_three_reg;
        acc_next        = acc_reg;

        result_next                 = '0;
        result_next.drive_forward   = dir_next[0];
        result_next.drive_backward  = dir_next[1];
        result_next.turn_left       = dir_next[2];
        result_next.turn_right      = dir_next[3];
        result_next.speed_high      = gear_next;

        if (head.item.is_close) begin
            result_next.frame_done   = 1'b1;
            result_next.frame_length = count_reg;
            priority if (byte_three_reg == rcbp_pkg::CODE_PID) begin
                result_next.pid_request = 1'b1;
            end else if (byte_three_reg == rcbp_pkg::CODE_FLASH) begin
                result_next.flash_request = 1'b1;
            end else if (byte_one_reg >= rcbp_pkg::CODE_GAIN_LO &&
                         byte_one_reg <= rcbp_pkg::CODE_GAIN_HI) begin
                result_next.gain_update     = 1'b1;
                result_next.gain_select     = byte_one_reg[rcbp_pkg::SEL_W-1:0];
                result_next.gain_hundredths = acc_reg;
            end else begin
                // no request
            end
            collecting_next = 1'b0;
            count_next      = '0;
            byte_one_next   = '0;
            byte_three_next = '0;
            acc_next        = '0;
        end else if (collect_now &&
                     count_reg < rcbp_pkg::COUNT_W'(MAX_FRAME_BYTES)) begin
            if (count_reg == rcbp_pkg::COUNT_W'(1)) begin
                byte_one_next = head.item.rx_byte;
            end
            if (count_reg == rcbp_pkg::COUNT_W'(3)) begin
                byte_three_next = head.item.rx_byte;
            end
            if (count_reg >= rcbp_pkg::COUNT_W'(3)) begin
                acc_next = acc_sat;
            end
            count_next = count_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            count_reg      <= '0;
            byte_one_reg   <= '0;
            byte_three_reg <= '0;
            acc_reg        <= '0;
            dir_reg        <= rcbp_pkg::DIR_STOP;
            gear_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (pop) begin
                collecting_reg <= collecting_next;
                count_reg      <= count_next;
                byte_one_reg   <= byte_one_next;
                byte_three_reg <= byte_three_next;
                acc_reg        <= acc_next;
                dir_reg        <= dir_next;
                gear_reg       <= gear_next;
                out_valid_reg  <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- rtl/rcbp_checker.sv -----
module rcbp_checker (
    input logic                                 aclk,
    input logic                                 aresetn,
    input logic                                 s_valid,
    input logic                                 s_ready,
    input logic [rcbp_pkg::BYTE_W-1:0]          s_rx_byte,
    input logic                                 m_valid,
    input logic                                 m_ready,
    input logic                                 m_drive_forward,
    input logic                                 m_drive_backward,
    input logic                                 m_turn_left,
    input logic                                 m_turn_right,
    input logic                                 m_speed_high,
    input logic                                 m_frame_done,
    input logic                                 m_pid_request,
    input logic                                 m_flash_request,
    input logic                                 m_gain_update,
    input logic [rcbp_pkg::SEL_W-1:0]           m_gain_select,
    input logic signed [rcbp_pkg::ACC_W-1:0]    m_gain_hundredths,
    input logic [rcbp_pkg::COUNT_W-1:0]         m_frame_length
);

    // Hold a stalled result beat
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_done)
            && $stable(m_gain_hundredths) && $stable(m_frame_length))
        else $error("stalled result beat changed");

    // Only a frame end carries a request or a length
    a_done_only: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_frame_done |-> !m_pid_request && !m_flash_request
            && !m_gain_update && m_frame_length == '0)
        else $error("request without frame end");

    // At most one request per frame
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_pid_request, m_flash_request, m_gain_update}))
        else $error("more than one request");

    // Gain fields are zero unless a gain is delivered
    a_gain_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_gain_update |-> m_gain_select == '0 && m_gain_hundredths == '0)
        else $error("gain fields set without gain update");

    // At most one drive direction at a time
    a_one_dir: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $onehot0({m_drive_forward, m_drive_backward, m_turn_left, m_turn_right}))
        else $error("more than one drive direction");

endmodule

bind remote_command_byte_parser_top rcbp_checker u_rcbp_checker (.*);

// ----- tb/tb_remote_command_byte_parser_top.sv -----
`timescale 1ns / 100ps

module tb_remote_command_byte_parser_top;

    // Frame limit used for both the DUT and the local predictor
    localparam int FRAME_LIMIT = rcbp_pkg::MAX_FRAME_BYTES_DEFAULT;

    // Marker in the byte queue: hold the sender until every result is back
    localparam int HOLD_FOR_DRAIN = -1;

    // Traffic shaping
    localparam int IDLE_PCT     = 28;
    localparam int CALM_FIRST   = 200;
    localparam int CALM_LAST    = 320;
    localparam int RANDOM_BYTES = 500;

    // Codes that the package does not name
    localparam logic [rcbp_pkg::BYTE_W-1:0] CODE_STOP_Z = 8'h5A;
    localparam logic [rcbp_pkg::BYTE_W-1:0] CODE_HASH   = 8'h23;

    localparam longint ACC_MAX = 64'sd2147483647;
    localparam longint ACC_MIN = -64'sd2147483648;

    logic                              aclk;
    logic                              aresetn;
    logic                              s_valid;
    logic                              s_ready;
    logic [rcbp_pkg::BYTE_W-1:0]       s_rx_byte;
    logic                              m_valid;
    logic                              m_ready;
    logic                              m_drive_forward;
    logic                              m_drive_backward;
    logic                              m_turn_left;
    logic                              m_turn_right;
    logic                              m_speed_high;
    logic                              m_frame_done;
    logic                              m_pid_request;
    logic                              m_flash_request;
    logic                              m_gain_update;
    logic [rcbp_pkg::SEL_W-1:0]        m_gain_select;
    logic signed [rcbp_pkg::ACC_W-1:0] m_gain_hundredths;
    logic [rcbp_pkg::COUNT_W-1:0]      m_frame_length;

    // Bytes waiting to be sent, and result beats waiting to be seen
    int                int_q_dummy;
    int                byte_q[$];
    rcbp_pkg::result_t expected_beats[$];

    // Local copy of the parser state
    logic                              frm_open;
    logic [rcbp_pkg::COUNT_W-1:0]      frm_count;
    logic [rcbp_pkg::BYTE_W-1:0]       frm_sel_byte;
    logic [rcbp_pkg::BYTE_W-1:0]       frm_op_byte;
    logic signed [rcbp_pkg::ACC_W-1:0] frm_acc;
    logic [rcbp_pkg::DIR_W-1:0]        drive_dir;
    logic                              drive_high;

    // Run statistics
    int n_sent;
    int n_checked;
    int n_errors;
    int n_frames;
    int n_pid;
    int n_flash;
    int n_gain;
    int n_clamped;

    remote_command_byte_parser_top #(
        .MAX_FRAME_BYTES(FRAME_LIMIT)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive_forward  (m_drive_forward),
        .m_drive_backward (m_drive_backward),
        .m_turn_left      (m_turn_left),
        .m_turn_right     (m_turn_right),
        .m_speed_high     (m_speed_high),
        .m_frame_done     (m_frame_done),
        .m_pid_request    (m_pid_request),
        .m_flash_request  (m_flash_request),
        .m_gain_update    (m_gain_update),
        .m_gain_select    (m_gain_select),
        .m_gain_hundredths(m_gain_hundredths),
        .m_frame_length   (m_frame_length)
    );

    // 4 ns clock
    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Map a direction code (letter offset already removed) to the flag vector
    function automatic logic [rcbp_pkg::DIR_W-1:0] dir_for(
        input logic [rcbp_pkg::BYTE_W-1:0] code
    );
        if (code == rcbp_pkg::DCODE_FWD) return rcbp_pkg::DIR_FWD;
        if (code == rcbp_pkg::DCODE_BACK) return rcbp_pkg::DIR_BACK;
        if (code >= rcbp_pkg::DCODE_RIGHT_LO && code <= rcbp_pkg::DCODE_RIGHT_HI)
            return rcbp_pkg::DIR_RIGHT;
        if (code >= rcbp_pkg::DCODE_LEFT_LO && code <= rcbp_pkg::DCODE_LEFT_HI)
            return rcbp_pkg::DIR_LEFT;
        return rcbp_pkg::DIR_STOP;
    endfunction

    // Advance the local parser state by one accepted byte and queue the
    // result beat it must produce.
    task automatic parse_byte(input logic [rcbp_pkg::BYTE_W-1:0] b);
        rcbp_pkg::result_t r;
        longint            nxt;
        r = '0;

        // Drive decoding: newline leaves flags and gear alone
        if (b > rcbp_pkg::CODE_NEWLINE) begin
            if (b == rcbp_pkg::CODE_GEAR_LOW) drive_high = 1'b0;
            if (b == rcbp_pkg::CODE_GEAR_HIGH) drive_high = 1'b1;
            if (b >= rcbp_pkg::CODE_LETTER_LO && b <= rcbp_pkg::CODE_LETTER_HI)
                drive_dir = dir_for(b - rcbp_pkg::CODE_LETTER_OFS);
            else
                drive_dir = rcbp_pkg::DIR_STOP;
        end else if (b < rcbp_pkg::CODE_NEWLINE) begin
            drive_high = 1'b1;
            drive_dir  = dir_for(b);
        end

        if (b == rcbp_pkg::CODE_OPEN) frm_open = 1'b1;

        if (b == rcbp_pkg::CODE_CLOSE) begin
            // Close ends the frame even when none is open; it is never stored
            r.frame_done   = 1'b1;
            r.frame_length = frm_count;
            n_frames++;
            if (frm_op_byte == rcbp_pkg::CODE_PID) begin
                r.pid_request = 1'b1;
                n_pid++;
            end else if (frm_op_byte == rcbp_pkg::CODE_FLASH) begin
                r.flash_request = 1'b1;
                n_flash++;
            end else if (frm_sel_byte >= rcbp_pkg::CODE_GAIN_LO &&
                         frm_sel_byte <= rcbp_pkg::CODE_GAIN_HI) begin
                r.gain_update     = 1'b1;
                r.gain_select     = rcbp_pkg::SEL_W'(frm_sel_byte - rcbp_pkg::CODE_GAIN_LO);
                r.gain_hundredths = frm_acc;
                n_gain++;
            end
            frm_open     = 1'b0;
            frm_count    = '0;
            frm_sel_byte = '0;
            frm_op_byte  = '0;
            frm_acc      = '0;
        end else if (frm_open && frm_count < FRAME_LIMIT) begin
            if (frm_count == 1) frm_sel_byte = b;
            if (frm_count == 3) frm_op_byte = b;
            if (frm_count >= 3) begin
                // Horner step on every stored byte from index 3 on, digit or not; saturate
                nxt = longint'(frm_acc) * 10 + longint'(b)
                    - longint'(rcbp_pkg::CODE_DIGIT_ZERO);
                if (nxt > ACC_MAX) begin
                    nxt = ACC_MAX;
                    n_clamped++;
                end else if (nxt < ACC_MIN) begin
                    nxt = ACC_MIN;
                    n_clamped++;
                end
                frm_acc = rcbp_pkg::ACC_W'(nxt);
            end
            frm_count++;
        end

        r.drive_forward  = drive_dir[0];
        r.drive_backward = drive_dir[1];
        r.turn_left      = drive_dir[2];
        r.turn_right     = drive_dir[3];
        r.speed_high     = drive_high;
        expected_beats.push_back(r);
    endtask

    task automatic check_field(input string nm, input longint want, input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, want, got);
            n_errors++;
        end
    endtask

    // Any byte except the close brace, so a frame body is not cut short
    function automatic logic [rcbp_pkg::BYTE_W-1:0] any_but_close();
        logic [rcbp_pkg::BYTE_W-1:0] v;
        v = rcbp_pkg::BYTE_W'($urandom_range(0, 255));
        if (v == rcbp_pkg::CODE_CLOSE) v = rcbp_pkg::CODE_OPEN;
        return v;
    endfunction

    // Queue one frame: mostly well formed with random content, some long
    // enough to hit the frame limit, some negative-leaning, a few unclosed.
    task automatic add_frame();
        int body;
        int op_pick;
        int low_fill;
        logic [rcbp_pkg::BYTE_W-1:0] v;
        body     = ($urandom_range(0, 9) == 0) ?
                   $urandom_range(FRAME_LIMIT - 6, FRAME_LIMIT + 6) : $urandom_range(0, 14);
        op_pick  = $urandom_range(0, 5);
        low_fill = ($urandom_range(0, 7) == 0);
        byte_q.push_back(rcbp_pkg::CODE_OPEN);
        for (int i = 1; i <= body; i++) begin
            if (i == 1) begin
                case ($urandom_range(0, 9))
                    0: v = CODE_HASH;
                    1: v = any_but_close();
                    default: v = rcbp_pkg::CODE_GAIN_LO
                               + rcbp_pkg::BYTE_W'($urandom_range(0, 3));
                endcase
            end else if (i == 3 && op_pick == 0) begin
                v = rcbp_pkg::CODE_PID;
            end else if (i == 3 && op_pick == 1) begin
                v = rcbp_pkg::CODE_FLASH;
            end else if (low_fill) begin
                v = rcbp_pkg::BYTE_W'($urandom_range(0, rcbp_pkg::CODE_DIGIT_ZERO - 1));
            end else if ($urandom_range(0, 99) < 85) begin
                v = rcbp_pkg::CODE_DIGIT_ZERO + rcbp_pkg::BYTE_W'($urandom_range(0, 9));
            end else begin
                v = any_but_close();
            end
            byte_q.push_back(v);
        end
        // Leave the odd frame open so the next brace lands inside it
        if ($urandom_range(0, 14) != 0) byte_q.push_back(rcbp_pkg::CODE_CLOSE);
    endtask

    // Sender: present queued bytes, hold each until accepted, idle at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                parse_byte(s_rx_byte);
                n_sent++;
            end
            if (!s_valid || s_ready) begin
                // Drop a drain marker only once nothing is outstanding
                if (byte_q.size() > 0 && byte_q[0] == HOLD_FOR_DRAIN
                        && expected_beats.size() == 0)
                    void'(byte_q.pop_front());
                if (byte_q.size() > 0 && byte_q[0] != HOLD_FOR_DRAIN &&
                        ((n_sent >= CALM_FIRST && n_sent < CALM_LAST) ||
                         $urandom_range(0, 99) >= IDLE_PCT)) begin
                    s_valid   <= 1'b1;
                    s_rx_byte <= rcbp_pkg::BYTE_W'(byte_q.pop_front());
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall at random, check each taken beat against the oldest
    // expectation, field by field.
    always @(posedge aclk) begin
        rcbp_pkg::result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: result beat with nothing expected", $time);
                    n_errors++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("drive_forward", want.drive_forward, m_drive_forward);
                    check_field("drive_backward", want.drive_backward, m_drive_backward);
                    check_field("turn_left", want.turn_left, m_turn_left);
                    check_field("turn_right", want.turn_right, m_turn_right);
                    check_field("speed_high", want.speed_high, m_speed_high);
                    check_field("frame_done", want.frame_done, m_frame_done);
                    check_field("pid_request", want.pid_request, m_pid_request);
                    check_field("flash_request", want.flash_request, m_flash_request);
                    check_field("gain_update", want.gain_update, m_gain_update);
                    check_field("gain_select", want.gain_select, m_gain_select);
                    check_field("gain_hundredths", want.gain_hundredths, m_gain_hundredths);
                    check_field("frame_length", want.frame_length, m_frame_length);
                end
                n_checked++;
            end
            m_ready <= (n_checked >= CALM_FIRST && n_checked < CALM_LAST) ||
                       ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_rx_byte    = '0;
        m_ready      = 1'b0;
        frm_open     = 1'b0;
        frm_count    = '0;
        frm_sel_byte = '0;
        frm_op_byte  = '0;
        frm_acc      = '0;
        drive_dir    = rcbp_pkg::DIR_STOP;
        drive_high   = 1'b0;
        n_sent       = 0;
        n_checked    = 0;
        n_errors     = 0;
        n_frames     = 0;
        n_pid        = 0;
        n_flash      = 0;
        n_gain       = 0;
        n_clamped    = 0;
        int_q_dummy  = 0;

        // Directed: byte extremes, newline, gears, every direction, stop,
        // close with no open frame, PID, flash, and a hash selector.
        byte_q = '{8'h00, 8'hFF, rcbp_pkg::CODE_NEWLINE, rcbp_pkg::CODE_GEAR_HIGH,
                   rcbp_pkg::CODE_LETTER_OFS + rcbp_pkg::DCODE_FWD,
                   rcbp_pkg::CODE_LETTER_OFS + rcbp_pkg::DCODE_BACK,
                   rcbp_pkg::CODE_LETTER_OFS + rcbp_pkg::DCODE_RIGHT_LO,
                   rcbp_pkg::CODE_LETTER_OFS + rcbp_pkg::DCODE_LEFT_HI,
                   rcbp_pkg::CODE_GEAR_LOW, CODE_STOP_Z, rcbp_pkg::CODE_CLOSE,
                   rcbp_pkg::CODE_OPEN, rcbp_pkg::CODE_GAIN_LO + 1,
                   rcbp_pkg::CODE_DIGIT_ZERO + 7, rcbp_pkg::CODE_PID,
                   rcbp_pkg::CODE_CLOSE,
                   rcbp_pkg::CODE_OPEN, rcbp_pkg::CODE_GAIN_LO + 2,
                   rcbp_pkg::CODE_DIGIT_ZERO, rcbp_pkg::CODE_FLASH,
                   rcbp_pkg::CODE_CLOSE,
                   rcbp_pkg::CODE_OPEN, CODE_HASH, rcbp_pkg::CODE_CLOSE};
        byte_q.push_back(HOLD_FOR_DRAIN);

        // Random: mostly frames, some raw noise, drain markers near halfway
        while (byte_q.size() < RANDOM_BYTES + 25) begin
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, 4)) byte_q.push_back($urandom_range(0, 255));
            end else begin
                add_frame();
            end
            if (byte_q.size() >= RANDOM_BYTES / 2 && byte_q.size() < RANDOM_BYTES / 2 + 20
                    && byte_q[$] != HOLD_FOR_DRAIN)
                byte_q.push_back(HOLD_FOR_DRAIN);
        end

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for the sender to empty and every result beat to be taken
        @(negedge aclk);
        while (byte_q.size() > 0 || s_valid || expected_beats.size() > 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("Run covered %0d bytes and %0d result beats; %0d frames closed",
                 n_sent, n_checked, n_frames);
        $display("Requests seen: %0d PID, %0d flash, %0d gain; %0d saturated digit steps",
                 n_pid, n_flash, n_gain, n_clamped + int_q_dummy);
        if (n_errors == 0 && expected_beats.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hang guard
    initial begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
